>>> rtl/rgbcpe_pkg.sv
// ----------------------------------------------------------------------------
// rgbcpe_pkg
// Shared types and constants of the RGB to composite phase encoder: color
// matrix coefficients, rounding constants, register indexes and the stage
// enable bundle handed to every pipeline section.
// ----------------------------------------------------------------------------
package rgbcpe_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_DARK_LEVEL   = 2'd0;
    localparam logic [1:0] REG_BRIGHT_LEVEL = 2'd1;
    localparam logic [1:0] REG_CHROMA_GAIN  = 2'd2;

    // Register reset values
    localparam logic [15:0] DARK_LEVEL_RST   = 16'd6144;
    localparam logic [15:0] BRIGHT_LEVEL_RST = 16'd51200;
    localparam logic [15:0] CHROMA_GAIN_RST  = 16'd1638;

    // Luma coefficients, Q0.16 (sum is exactly 1.0)
    localparam logic [24:0] Y_R = 25'd19595;
    localparam logic [24:0] Y_G = 25'd38470;
    localparam logic [24:0] Y_B = 25'd7471;

    // Color difference coefficients, signed Q1.15 (each row sums to zero)
    localparam logic signed [23:0] U_R = -24'sd4830;
    localparam logic signed [23:0] U_G = -24'sd9483;
    localparam logic signed [23:0] U_B = 24'sd14313;
    localparam logic signed [23:0] V_R = 24'sd20145;
    localparam logic signed [23:0] V_G = -24'sd16869;
    localparam logic signed [23:0] V_B = -24'sd3276;

    // Half of 255 * 65536, the luma rounding offset
    localparam logic [41:0] LUMA_HALF   = 42'd8355840;
    // Half of 2^19, the chroma rounding offset
    localparam logic [40:0] CHROMA_HALF = 41'd262144;
    // floor((2^32 - 1) / 255), reciprocal for the divide by 255
    localparam logic [24:0] RECIP_255   = 25'h1010101;
    localparam logic [25:0] DIV_255     = 26'd255;

    typedef struct packed {
        logic [15:0] dark_level;
        logic [15:0] bright_level;
        logic [15:0] chroma_gain;
    } cfg_t;

    // Load enables of the six pipeline registers, input side first
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } stage_en_t;

endpackage

>>> rtl/rgbcpe_cfg.sv
// ----------------------------------------------------------------------------
// rgbcpe_cfg
// Configuration register file: black level, white level and chroma gain.
// Writes to an unused index are dropped.
// ----------------------------------------------------------------------------
module rgbcpe_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output rgbcpe_pkg::cfg_t   cfg
);

    rgbcpe_pkg::cfg_t cfg_reg;
    rgbcpe_pkg::cfg_t cfg_next;

    // Always take writes
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                rgbcpe_pkg::REG_DARK_LEVEL:   cfg_next.dark_level   = cfg_data;
                rgbcpe_pkg::REG_BRIGHT_LEVEL: cfg_next.bright_level = cfg_data;
                rgbcpe_pkg::REG_CHROMA_GAIN:  cfg_next.chroma_gain  = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dark_level   <= rgbcpe_pkg::DARK_LEVEL_RST;
            cfg_reg.bright_level <= rgbcpe_pkg::BRIGHT_LEVEL_RST;
            cfg_reg.chroma_gain  <= rgbcpe_pkg::CHROMA_GAIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/rgbcpe_matrix.sv
// ----------------------------------------------------------------------------
// rgbcpe_matrix
// First pipeline stage: RGB to Y (Q8.16) and U, V (signed Q9.15) by the
// fixed color matrix.
// ----------------------------------------------------------------------------
module rgbcpe_matrix (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rgbcpe_pkg::stage_en_t   en,
    input  logic [23:0]             rgb_color,
    output logic [24:0]             ys,
    output logic signed [23:0]      u15,
    output logic signed [23:0]      v15
);

    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic [24:0]        ys_reg;
    logic [24:0]        ys_next;
    logic signed [23:0] u15_reg;
    logic signed [23:0] u15_next;
    logic signed [23:0] v15_reg;
    logic signed [23:0] v15_next;

    assign r = rgb_color[23:16];
    assign g = rgb_color[15:8];
    assign b = rgb_color[7:0];

    // Apply the matrix
    always_comb
    begin
        ys_next  = rgbcpe_pkg::Y_R * 25'(r) + rgbcpe_pkg::Y_G * 25'(g)
                 + rgbcpe_pkg::Y_B * 25'(b);
        u15_next = rgbcpe_pkg::U_R * $signed(24'(r)) + rgbcpe_pkg::U_G * $signed(24'(g))
                 + rgbcpe_pkg::U_B * $signed(24'(b));
        v15_next = rgbcpe_pkg::V_R * $signed(24'(r)) + rgbcpe_pkg::V_G * $signed(24'(g))
                 + rgbcpe_pkg::V_B * $signed(24'(b));
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            ys_reg  <= ys_next;
            u15_reg <= u15_next;
            v15_reg <= v15_next;
        end
    end

    assign ys  = ys_reg;
    assign u15 = u15_reg;
    assign v15 = v15_reg;

    // A gray input carries no chroma and a luma of exactly the gray level
    a_gray_neutral: assert property (@(posedge clk) disable iff (!rst_n)
        en.s1 && (r == g) && (g == b)
        |=> (u15_reg == 24'sd0) && (v15_reg == 24'sd0)
            && (ys_reg == {1'b0, $past(rgb_color[23:16]), 16'h0000}))
        else $error("gray input gave nonzero chroma or wrong luma");

endmodule

>>> rtl/rgbcpe_scale.sv
// ----------------------------------------------------------------------------
// rgbcpe_scale
// Stages two to five: map luma onto the black..white span with a divide by
// 255 * 65536 (shift, reciprocal multiply, one correction step) and scale
// chroma by the gain, each rounded half away from zero to 8 fraction bits.
// ----------------------------------------------------------------------------
module rgbcpe_scale (
    input  logic                    clk,
    input  rgbcpe_pkg::stage_en_t   en,
    input  rgbcpe_pkg::cfg_t        cfg,
    input  logic [24:0]             ys,
    input  logic signed [23:0]      u15,
    input  logic signed [23:0]      v15,
    output logic signed [17:0]      y8,
    output logic signed [20:0]      u8,
    output logic signed [20:0]      v8
);

    // Round a chroma product by 2^19, half away from zero
    function automatic logic signed [20:0] round_chroma(input logic signed [40:0] p);
        logic [40:0] mag;
        logic [40:0] sum;
        logic [20:0] q;
        mag = p[40] ? 41'(-p) : 41'(p);
        sum = mag + rgbcpe_pkg::CHROMA_HALF;
        q   = sum[39:19];
        return p[40] ? -$signed(q) : $signed(q);
    endfunction

    // Stage 2: products
    logic signed [16:0] span;
    logic signed [16:0] gain_s;
    logic signed [25:0] ys_s;
    logic signed [41:0] prod_y_reg;
    logic signed [41:0] prod_y_next;
    logic signed [40:0] prod_u_reg;
    logic signed [40:0] prod_u_next;
    logic signed [40:0] prod_v_reg;
    logic signed [40:0] prod_v_next;

    // Stage 3: rounding offsets and shifts
    logic [41:0]        y_mag;
    logic [41:0]        y_sum;
    logic [24:0]        t3_reg;
    logic [24:0]        t3_next;
    logic               yneg3_reg;
    logic signed [20:0] u3_reg;
    logic signed [20:0] v3_reg;

    // Stage 4: reciprocal multiply
    logic [49:0]        p4_reg;
    logic [49:0]        p4_next;
    logic [24:0]        t4_reg;
    logic               yneg4_reg;
    logic signed [20:0] u4_reg;
    logic signed [20:0] v4_reg;

    // Stage 5: quotient correction
    logic [16:0]        q_est;
    logic [25:0]        rem;
    logic [16:0]        q;
    logic signed [17:0] y8_reg;
    logic signed [17:0] y8_next;
    logic signed [20:0] u5_reg;
    logic signed [20:0] v5_reg;

    // Form the luma span and chroma products
    always_comb
    begin
        span        = $signed({1'b0, cfg.bright_level}) - $signed({1'b0, cfg.dark_level});
        gain_s      = $signed({1'b0, cfg.chroma_gain});
        ys_s        = $signed({1'b0, ys});
        prod_y_next = 42'(ys_s) * 42'(span);
        prod_u_next = 41'(u15) * 41'(gain_s);
        prod_v_next = 41'(v15) * 41'(gain_s);
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            prod_y_reg <= prod_y_next;
            prod_u_reg <= prod_u_next;
            prod_v_reg <= prod_v_next;
        end
    end

    // Round luma magnitude and drop the 65536 factor of the divisor
    always_comb
    begin
        y_mag   = prod_y_reg[41] ? 42'(-prod_y_reg) : 42'(prod_y_reg);
        y_sum   = y_mag + rgbcpe_pkg::LUMA_HALF;
        t3_next = y_sum[40:16];
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            t3_reg    <= t3_next;
            yneg3_reg <= prod_y_reg[41];
            u3_reg    <= round_chroma(prod_u_reg);
            v3_reg    <= round_chroma(prod_v_reg);
        end
    end

    // Multiply by the reciprocal of 255
    assign p4_next = 50'(t3_reg) * 50'(rgbcpe_pkg::RECIP_255);

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            p4_reg    <= p4_next;
            t4_reg    <= t3_reg;
            yneg4_reg <= yneg3_reg;
            u4_reg    <= u3_reg;
            v4_reg    <= v3_reg;
        end
    end

    // Fix the estimate, which is low by at most one, and add black
    always_comb
    begin
        q_est   = p4_reg[48:32];
        rem     = 26'(t4_reg) - 26'({q_est, 8'h00}) + 26'(q_est);
        q       = q_est + 17'(rem >= rgbcpe_pkg::DIV_255);
        y8_next = $signed({2'b00, cfg.dark_level})
                + (yneg4_reg ? -$signed({1'b0, q}) : $signed({1'b0, q}));
    end

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            y8_reg <= y8_next;
            u5_reg <= u4_reg;
            v5_reg <= v4_reg;
        end
    end

    assign y8 = y8_reg;
    assign u8 = u5_reg;
    assign v8 = v5_reg;

endmodule

>>> rtl/rgbcpe_sample.sv
// ----------------------------------------------------------------------------
// rgbcpe_sample
// Output stage: form the four phase samples, round and saturate them to
// 0..255, and pack the even and odd line words.
// ----------------------------------------------------------------------------
module rgbcpe_sample (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rgbcpe_pkg::stage_en_t   en,
    input  logic                    in_valid,
    input  logic signed [17:0]      y8,
    input  logic signed [20:0]      u8,
    input  logic signed [20:0]      v8,
    output logic [31:0]             even_line_word,
    output logic [31:0]             odd_line_word
);

    // Round by 256 half away from zero and clamp to 0..255
    function automatic logic [7:0] sat_sample(input logic signed [21:0] s);
        logic [21:0] r;
        r = 22'(s) + 22'd128;
        if (s[21])
            return 8'd0;
        else if (r[21:16] != 6'd0)
            return 8'd255;
        else
            return r[15:8];
    endfunction

    logic signed [21:0] y_s;
    logic signed [21:0] u_s;
    logic signed [21:0] v_s;
    logic [7:0]         ymv;
    logic [7:0]         ymu;
    logic [7:0]         ypv;
    logic [7:0]         ypu;
    logic [31:0]        even_reg;
    logic [31:0]        even_next;
    logic [31:0]        odd_reg;
    logic [31:0]        odd_next;

    // Build the four phases
    always_comb
    begin
        y_s       = 22'(y8);
        u_s       = 22'(u8);
        v_s       = 22'(v8);
        ymv       = sat_sample(y_s - v_s);
        ymu       = sat_sample(y_s - u_s);
        ypv       = sat_sample(y_s + v_s);
        ypu       = sat_sample(y_s + u_s);
        even_next = {ymv, ymu, ypv, ypu};
        odd_next  = {ypv, ymu, ymv, ypu};
    end

    always_ff @(posedge clk)
    begin
        if (en.s6)
        begin
            even_reg <= even_next;
            odd_reg  <= odd_next;
        end
    end

    assign even_line_word = even_reg;
    assign odd_line_word  = odd_reg;

    // Odd word is the even word with the V phases swapped
    a_odd_swaps_v: assert property (@(posedge clk) disable iff (!rst_n)
        en.s6 && in_valid
        |=> (even_reg[31:24] == odd_reg[15:8]) && (even_reg[15:8] == odd_reg[31:24])
            && (even_reg[23:16] == odd_reg[23:16]) && (even_reg[7:0] == odd_reg[7:0]))
        else $error("odd line word does not mirror the V phases of the even word");

endmodule

>>> rtl/rgb_to_composite_phase_encoder.sv
// ----------------------------------------------------------------------------
// rgb_to_composite_phase_encoder
// Encodes one 24-bit RGB color into two words of four composite samples.
//
// Input channel: rgb_color with pix_valid / pix_stall. Output channel:
// even_line_word and odd_line_word with word_valid / word_stall. An item
// moves at a clock edge where valid is high and stall is low.
// Configuration: cfg_valid / cfg_ready with cfg_index (0 black level,
// 1 white level, 2 chroma gain) and cfg_data; cfg_ready is always high and
// writes to index 3 are dropped. Write only while the pipeline is empty.
// word_valid is the valid bit of the last stage; with no output stall one
// item per cycle is sustained.
// The six register stages are: color matrix, span and gain
// multiplies, rounding, reciprocal multiply for the divide by 255, quotient
// correction, and sample saturation with packing.
// An output stall freezes full stages with no empty stage after them; empty
// stages keep filling, and pix_stall rises only when all six hold an item.
// Reset clears all stages and loads the register reset values.
// ----------------------------------------------------------------------------
module rgb_to_composite_phase_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pix_valid,
    output logic        pix_stall,
    input  logic [23:0] rgb_color,
    output logic        word_valid,
    input  logic        word_stall,
    output logic [31:0] even_line_word,
    output logic [31:0] odd_line_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    rgbcpe_pkg::cfg_t       cfg;
    rgbcpe_pkg::stage_en_t  en;
    logic [5:0]             vld_reg;
    logic [5:0]             vld_next;
    logic [5:0]             adv;
    logic [24:0]            ys;
    logic signed [23:0]     u15;
    logic signed [23:0]     v15;
    logic signed [17:0]     y8;
    logic signed [20:0]     u8;
    logic signed [20:0]     v8;

    // Advance a stage when it is empty or the next one advances
    always_comb
    begin
        adv[5] = !vld_reg[5] || !word_stall;
        for (int k = 4; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k + 1];
        end
        vld_next[0] = adv[0] ? pix_valid : vld_reg[0];
        for (int k = 1; k < 6; k++)
        begin
            vld_next[k] = adv[k] ? vld_reg[k - 1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 6'd0;
        else
            vld_reg <= vld_next;
    end

    assign en.s1      = adv[0];
    assign en.s2      = adv[1];
    assign en.s3      = adv[2];
    assign en.s4      = adv[3];
    assign en.s5      = adv[4];
    assign en.s6      = adv[5];
    assign pix_stall  = !adv[0];
    assign word_valid = vld_reg[5];

    rgbcpe_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rgbcpe_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .rgb_color (rgb_color),
        .ys        (ys),
        .u15       (u15),
        .v15       (v15)
    );

    rgbcpe_scale u_scale (
        .clk (clk),
        .en  (en),
        .cfg (cfg),
        .ys  (ys),
        .u15 (u15),
        .v15 (v15),
        .y8  (y8),
        .u8  (u8),
        .v8  (v8)
    );

    rgbcpe_sample u_sample (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (vld_reg[4]),
        .y8             (y8),
        .u8             (u8),
        .v8             (v8),
        .even_line_word (even_line_word),
        .odd_line_word  (odd_line_word)
    );

    // Input backpressure only when every stage is occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> (&vld_reg))
        else $error("input stalled while a pipeline stage is empty");

    // A full pipeline under output stall holds every item
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (&vld_reg) && word_stall |=> $stable(vld_reg))
        else $error("full pipeline changed occupancy while stalled");

endmodule

>>> tb/sv/rgbcpe_word_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbcpe_word_checker
// Watches the pixel, word and configuration channels of the composite phase
// encoder. Keeps its own copy of the level and gain registers, computes the
// even and odd line words for every accepted color, and compares each
// accepted word pair against the oldest pending prediction.
// ----------------------------------------------------------------------------
module rgbcpe_word_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pix_valid,
    input  logic        pix_stall,
    input  logic [23:0] rgb_color,
    input  logic        word_valid,
    input  logic        word_stall,
    input  logic [31:0] even_line_word,
    input  logic [31:0] odd_line_word,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          outstanding,
    output int          error_count
);

    // Color matrix: luma in Q0.16, color differences in signed Q1.15
    localparam longint LUMA_R = 19595;
    localparam longint LUMA_G = 38470;
    localparam longint LUMA_B = 7471;
    localparam longint CU_R   = -4830;
    localparam longint CU_G   = -9483;
    localparam longint CU_B   = 14313;
    localparam longint CV_R   = 20145;
    localparam longint CV_G   = -16869;
    localparam longint CV_B   = -3276;
    // 255 * 2^16 for the luma span, 2^19 for the chroma gain
    localparam longint LUMA_DIV   = 64'd16711680;
    localparam longint CHROMA_DIV = 64'd524288;

    typedef struct packed {
        logic [31:0] even_word;
        logic [31:0] odd_word;
    } line_words_t;

    line_words_t       encoded_q[$];
    rgbcpe_pkg::cfg_t  level_regs;
    int                mismatches;

    // Divide and round half away from zero
    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    // Drop the 8 fraction bits with rounding and clamp to one sample
    function automatic logic [7:0] clip_sample(longint y8, longint c8);
        longint s;
        s = round_div(y8 + c8, 256);
        if (s < 0)
            s = 0;
        if (s > 255)
            s = 255;
        return s[7:0];
    endfunction

    function automatic line_words_t encode_color(logic [23:0] c, rgbcpe_pkg::cfg_t regs);
        longint      r, g, b;
        longint      ys, u15, v15;
        longint      span, y8, u8, v8;
        logic [7:0]  ymv, ymu, ypv, ypu;
        line_words_t w;
        r = longint'(c[23:16]);
        g = longint'(c[15:8]);
        b = longint'(c[7:0]);
        ys  = LUMA_R * r + LUMA_G * g + LUMA_B * b;
        u15 = CU_R * r + CU_G * g + CU_B * b;
        v15 = CV_R * r + CV_G * g + CV_B * b;
        // span goes negative when white sits below black
        span = longint'(regs.bright_level) - longint'(regs.dark_level);
        y8 = longint'(regs.dark_level) + round_div(ys * span, LUMA_DIV);
        u8 = round_div(u15 * longint'(regs.chroma_gain), CHROMA_DIV);
        v8 = round_div(v15 * longint'(regs.chroma_gain), CHROMA_DIV);
        ymv = clip_sample(y8, -v8);
        ymu = clip_sample(y8, -u8);
        ypv = clip_sample(y8, v8);
        ypu = clip_sample(y8, u8);
        w.even_word = {ymv, ymu, ypv, ypu};
        w.odd_word  = {ypv, ymu, ymv, ypu};
        return w;
    endfunction

    task automatic report_error(string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        mismatches++;
    endtask

    // Track registers, queue predictions, compare words
    always @(posedge clk or negedge rst_n)
    begin : watch
        line_words_t want;
        if (!rst_n)
        begin
            level_regs.dark_level   = rgbcpe_pkg::DARK_LEVEL_RST;
            level_regs.bright_level = rgbcpe_pkg::BRIGHT_LEVEL_RST;
            level_regs.chroma_gain  = rgbcpe_pkg::CHROMA_GAIN_RST;
            encoded_q.delete();
            mismatches = 0;
            outstanding <= 0;
            error_count <= 0;
        end
        else
        begin
            // Apply register writes; unknown index is dropped
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rgbcpe_pkg::REG_DARK_LEVEL:   level_regs.dark_level   = cfg_data;
                    rgbcpe_pkg::REG_BRIGHT_LEVEL: level_regs.bright_level = cfg_data;
                    rgbcpe_pkg::REG_CHROMA_GAIN:  level_regs.chroma_gain  = cfg_data;
                    default: ;
                endcase
            end

            // Compare the outgoing item before queueing the incoming one
            if (word_valid && !word_stall)
            begin
                if (encoded_q.size() == 0)
                begin
                    report_error($sformatf("word pair %08h/%08h with no color pending",
                                           even_line_word, odd_line_word));
                end
                else
                begin
                    want = encoded_q.pop_front();
                    if (even_line_word !== want.even_word)
                        report_error($sformatf("even_line_word got %08h want %08h",
                                               even_line_word, want.even_word));
                    if (odd_line_word !== want.odd_word)
                        report_error($sformatf("odd_line_word got %08h want %08h",
                                               odd_line_word, want.odd_word));
                end
            end

            if (pix_valid && !pix_stall)
                encoded_q.push_back(encode_color(rgb_color, level_regs));

            outstanding <= encoded_q.size();
            error_count <= mismatches;
        end
    end

endmodule

>>> tb/sv/rgb_to_composite_phase_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_composite_phase_encoder_tb
// Drives colors through the composite phase encoder in bursts with random
// gaps while the word side stalls on its own pattern, including one long
// hold-off that backs the pipeline up. Runs a directed set of corner colors,
// then random colors under several level and gain settings, extremes among
// them. A separate checker predicts and compares every word pair.
// ----------------------------------------------------------------------------
module rgb_to_composite_phase_encoder_tb;

    localparam int          CLK_HALF        = 4;
    localparam int          RESET_CYCLES    = 9;
    localparam int          PHASE_COUNT     = 7;
    localparam int          PHASE_ITEMS     = 107;
    localparam int          CORNER_COUNT    = 20;
    localparam int          HOLD_OFF_CYCLES = 240;
    localparam int          SETTLE_CYCLES   = 16;
    localparam int          IDLE_LIMIT      = 2000;
    localparam logic [1:0]  REG_UNUSED      = 2'd3;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PULSE} stall_mode_t;

    logic        clk;
    logic        rst_n;
    logic        pix_valid;
    logic        pix_stall;
    logic [23:0] rgb_color;
    logic        word_valid;
    logic        word_stall;
    logic [31:0] even_line_word;
    logic [31:0] odd_line_word;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int outstanding;
    int error_count;
    int hold_req_cnt;
    int burst_left;
    int idle_cycles;

    rgb_to_composite_phase_encoder u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .pix_valid      (pix_valid),
        .pix_stall      (pix_stall),
        .rgb_color      (rgb_color),
        .word_valid     (word_valid),
        .word_stall     (word_stall),
        .even_line_word (even_line_word),
        .odd_line_word  (odd_line_word),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    rgbcpe_word_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .pix_valid      (pix_valid),
        .pix_stall      (pix_stall),
        .rgb_color      (rgb_color),
        .word_valid     (word_valid),
        .word_stall     (word_stall),
        .even_line_word (even_line_word),
        .odd_line_word  (odd_line_word),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .outstanding    (outstanding),
        .error_count    (error_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Primaries, grays, single-bit and alternating patterns
    function automatic logic [23:0] corner_color(int i);
        case (i)
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return 24'hFF0000;
            3:       return 24'h00FF00;
            4:       return 24'h0000FF;
            5:       return 24'hFFFF00;
            6:       return 24'h00FFFF;
            7:       return 24'hFF00FF;
            8:       return 24'h808080;
            9:       return 24'h7F7F7F;
            10:      return 24'h010101;
            11:      return 24'hFEFEFE;
            12:      return 24'hAAAAAA;
            13:      return 24'h555555;
            14:      return 24'hC0C0C0;
            15:      return 24'h123456;
            16:      return 24'hFEDCBA;
            17:      return 24'h800000;
            18:      return 24'h008000;
            default: return 24'h000080;
        endcase
    endfunction

    // Mix fully random colors, saturated channel corners and grays
    function automatic logic [23:0] pick_color();
        logic [23:0] c;
        logic [7:0]  gray;
        int          k;
        c = 24'($urandom_range(0, 24'hFFFFFF));
        case ($urandom_range(0, 3))
            1:
            begin
                for (k = 0; k < 3; k++)
                begin
                    case ($urandom_range(0, 2))
                        0:       c[k*8 +: 8] = 8'h00;
                        1:       c[k*8 +: 8] = 8'hFF;
                        default: c[k*8 +: 8] = 8'($urandom_range(0, 255));
                    endcase
                end
            end
            2:
            begin
                gray = 8'($urandom_range(0, 255));
                c = {gray, gray, gray};
            end
            default: ;
        endcase
        return c;
    endfunction

    // Offer one color; open a gap first when the current burst is used up
    task automatic offer_color(logic [23:0] c);
        if (burst_left == 0)
        begin
            pix_valid <= 1'b0;
            rgb_color <= 24'($urandom_range(0, 24'hFFFFFF));
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        pix_valid <= 1'b1;
        rgb_color <= c;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
    endtask

    // Hold valid high; the caller lowers it after the last write
    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic load_setting(logic [15:0] dark, logic [15:0] bright, logic [15:0] gain);
        write_reg(rgbcpe_pkg::REG_DARK_LEVEL, dark);
        write_reg(rgbcpe_pkg::REG_BRIGHT_LEVEL, bright);
        write_reg(rgbcpe_pkg::REG_CHROMA_GAIN, gain);
        // unknown index must leave every register alone
        write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_words_drained();
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Main stimulus
    initial
    begin : stimulus
        int p;
        int i;
        rst_n        = 1'b0;
        pix_valid    = 1'b0;
        rgb_color    = 24'h000000;
        cfg_valid    = 1'b0;
        cfg_index    = rgbcpe_pkg::REG_DARK_LEVEL;
        cfg_data     = 16'h0000;
        hold_req_cnt = 0;
        burst_left   = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner colors under reset levels
        for (i = 0; i < CORNER_COUNT; i++)
            offer_color(corner_color(i));
        pix_valid <= 1'b0;
        wait_words_drained();

        for (p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:       load_setting(rgbcpe_pkg::DARK_LEVEL_RST,
                                      rgbcpe_pkg::BRIGHT_LEVEL_RST,
                                      rgbcpe_pkg::CHROMA_GAIN_RST);
                1:       load_setting(16'h0000, 16'hFFFF, 16'hFFFF);
                2:       load_setting(16'hFFFF, 16'h0000, 16'h0000);
                3:       load_setting(16'h8000, 16'h8000, 16'h1000);
                4:       load_setting(16'($urandom_range(0, 65535)),
                                      16'($urandom_range(0, 65535)),
                                      16'($urandom_range(0, 65535)));
                5:       load_setting(16'($urandom_range(0, 8192)),
                                      16'($urandom_range(40000, 65535)),
                                      16'($urandom_range(0, 4095)));
                default: load_setting(16'($urandom_range(0, 65535)),
                                      16'($urandom_range(0, 65535)),
                                      16'($urandom_range(0, 65535)));
            endcase

            // Long word-side hold-off while colors keep coming
            if (p == 2)
            begin
                hold_req_cnt = hold_req_cnt + 1;
                burst_left = 300;
            end

            for (i = 0; i < PHASE_ITEMS; i++)
                offer_color(pick_color());
            pix_valid <= 1'b0;
            wait_words_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Word-side stall pattern, with long hold-offs on request
    initial
    begin : word_receiver
        stall_mode_t mode;
        int          seg_left;
        int          hold_done_cnt;
        word_stall    = 1'b0;
        mode          = STALL_NONE;
        seg_left      = 0;
        hold_done_cnt = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_done_cnt != hold_req_cnt)
            begin
                hold_done_cnt++;
                word_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode = stall_mode_t'($urandom_range(0, 3));
                    seg_left = $urandom_range(8, 80);
                end
                seg_left--;
                case (mode)
                    STALL_NONE:  word_stall <= 1'b0;
                    STALL_LIGHT: word_stall <= ($urandom_range(0, 7) == 0);
                    STALL_HEAVY: word_stall <= ($urandom_range(0, 3) != 0);
                    default:     word_stall <= seg_left[2];
                endcase
                @(posedge clk);
            end
        end
    end

    // Watchdog: end the run when no channel moves for too long
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (pix_valid && !pix_stall) || (word_valid && !word_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule
